// ===== hw/rtl/gaps_pkg.sv =====
`default_nettype none
package gaps_pkg;

  // Grid geometry
  localparam int CELLS = 4096;
  localparam int AW = 12;
  localparam logic [6:0] MAX_W = 7'd64;
  localparam logic [6:0] MAX_H = 7'd64;
  localparam logic [12:0] CELL_COUNT = 13'd4096;

  // Step costs
  localparam logic [4:0] COST_STRAIGHT = 5'd10;
  localparam logic [4:0] COST_DIAG = 5'd14;

  // Heuristic codes; any other code acts as Manhattan
  localparam logic [1:0] HEUR_EUCLID = 2'd1;
  localparam logic [1:0] HEUR_OCT = 2'd2;

  typedef enum logic [1:0] {
    ACT_WALL   = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_EIGHT_WAY   = 3'd2,
    REG_HEUR_MODE   = 3'd3,
    REG_START_X     = 3'd4,
    REG_START_Y     = 3'd5,
    REG_GOAL_X      = 3'd6,
    REG_GOAL_Y      = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [6:0] grid_width;
    logic [6:0] grid_height;
    logic       eight_way;
    logic [1:0] heuristic_mode;
    logic [5:0] start_x;
    logic [5:0] start_y;
    logic [5:0] goal_x;
    logic [5:0] goal_y;
  } cfg_t;

  typedef struct packed {
    action_t    action;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic       is_wall;
  } req_t;

  typedef struct packed {
    logic        found;
    logic [12:0] path_length;
    logic [5:0]  step_x;
    logic [5:0]  step_y;
    logic        step_valid;
    logic        last_step;
  } res_t;

  typedef struct packed {
    logic       start;
    logic [5:0] x;
    logic [5:0] y;
  } heur_req_t;

  // One node entry: open/closed marks, G, H and the direction taken to reach it
  typedef struct packed {
    logic        open;
    logic        closed;
    logic [15:0] g;
    logic [10:0] h;
    logic [2:0]  dir;
  } node_t;

  function automatic logic signed [1:0] dir_dx(input logic [2:0] d);
    logic signed [1:0] r;
    case (d)
      3'd1, 3'd5, 3'd7: r = 2'sb01;
      3'd3, 3'd4, 3'd6: r = 2'sb11;
      default:          r = 2'sb00;
    endcase
    return r;
  endfunction

  function automatic logic signed [1:0] dir_dy(input logic [2:0] d);
    logic signed [1:0] r;
    case (d)
      3'd0, 3'd5, 3'd6: r = 2'sb01;
      3'd2, 3'd4, 3'd7: r = 2'sb11;
      default:          r = 2'sb00;
    endcase
    return r;
  endfunction

  // Step back against a direction; top bit flags a cell inside the full grid
  function automatic logic [12:0] parent_of(input logic [11:0] idx, input logic [2:0] dir);
    logic signed [1:0] ddx;
    logic signed [1:0] ddy;
    logic [7:0] px;
    logic [7:0] py;
    ddx = dir_dx(dir);
    ddy = dir_dy(dir);
    px = {2'b00, idx[5:0]} - {{6{ddx[1]}}, ddx};
    py = {2'b00, idx[11:6]} - {{6{ddy[1]}}, ddy};
    return {(px[7:6] == 2'b00) && (py[7:6] == 2'b00), py[5:0], px[5:0]};
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/grid_astar_path_search.sv =====
// Sequence: a search first clears the node marks; then each expansion scans the whole node
//   memory for the open cell of least G+H and evaluates each neighbour with the heuristic
//   unit; finally it traces the path back from the goal cell to the start cell.
// Throughput: one request at a time; the scan over the node memory sets the search time.
// Reset: synchronous; after reset a pass over every cell clears the wall memory, no request is taken meanwhile.
`default_nettype none
module grid_astar_path_search
  import gaps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,  // cell_x[5:0], cell_y[11:6], is_wall[12], zero fill
  input  wire logic [1:0]  s_tuser,  // action[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // found[0], path_length[13:1], step_x[19:14],
                                     // step_y[25:20], step_valid[26], zero fill
  output logic             m_tlast,  // last_step
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t     cfg;
  req_t     req;
  res_t     res;
  logic     core_ready;
  logic     res_valid;
  logic     res_take;
  reg_idx_t reg_sel;

  assign pready = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[4:2]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{grid_width: MAX_W, grid_height: MAX_H, eight_way: 1'b0,
               heuristic_mode: 2'd0, start_x: 6'd0, start_y: 6'd0,
               goal_x: 6'd0, goal_y: 6'd0};
    end else if (psel && penable && pwrite && pready) begin
      case (reg_sel)
        REG_GRID_WIDTH:  cfg.grid_width <= pwdata[6:0];
        REG_GRID_HEIGHT: cfg.grid_height <= pwdata[6:0];
        REG_EIGHT_WAY:   cfg.eight_way <= pwdata[0];
        REG_HEUR_MODE:   cfg.heuristic_mode <= pwdata[1:0];
        REG_START_X:     cfg.start_x <= pwdata[5:0];
        REG_START_Y:     cfg.start_y <= pwdata[5:0];
        REG_GOAL_X:      cfg.goal_x <= pwdata[5:0];
        REG_GOAL_Y:      cfg.goal_y <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_sel)
      REG_GRID_WIDTH:  prdata = {25'd0, cfg.grid_width};
      REG_GRID_HEIGHT: prdata = {25'd0, cfg.grid_height};
      REG_EIGHT_WAY:   prdata = {31'd0, cfg.eight_way};
      REG_HEUR_MODE:   prdata = {30'd0, cfg.heuristic_mode};
      REG_START_X:     prdata = {26'd0, cfg.start_x};
      REG_START_Y:     prdata = {26'd0, cfg.start_y};
      REG_GOAL_X:      prdata = {26'd0, cfg.goal_x};
      REG_GOAL_Y:      prdata = {26'd0, cfg.goal_y};
      default:         prdata = '0;
    endcase
  end

  assign req = '{action: action_t'(s_tuser), cell_x: s_tdata[5:0],
                 cell_y: s_tdata[11:6], is_wall: s_tdata[12]};
  assign s_tready = core_ready;

  gaps_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (s_tvalid),
    .req       (req),
    .ready     (core_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // Output register: load when empty or being drained
  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tdata <= {5'd0, res.step_valid, res.step_y, res.step_x, res.path_length, res.found};
      m_tlast <= res.last_step;
    end
  end

`ifndef ASSERT_OFF
  // A path length is reported exactly when the search found the goal
  a_found_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[0] == (m_tdata[13:1] != 13'd0)))
    else $error("found and path_length disagree");

  // The start-cell mark comes only with a returned cell
  a_last_step: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[26]) |-> (!m_tlast && m_tdata[25:14] == 12'd0))
    else $error("step fields set without a returned cell");

  // The core never takes a request while it still holds a result
  a_core_busy: assert property (@(posedge clk) disable iff (rst)
    !(core_ready && res_valid))
    else $error("core ready while a result is pending");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/gaps_heur.sv =====
`default_nettype none
module gaps_heur
  import gaps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire heur_req_t   req,
  input  wire logic [5:0]  goal_x,
  input  wire logic [5:0]  goal_y,
  input  wire logic [1:0]  mode,
  output logic             done,
  output logic [10:0]      h
);

  typedef enum logic [3:0] {
    HS_IDLE  = 4'b0001,
    HS_SQ    = 4'b0010,
    HS_SCALE = 4'b0100,
    HS_ROOT  = 4'b1000
  } hstate_t;

  hstate_t     state;
  logic [5:0]  dx;
  logic [5:0]  dy;
  logic [12:0] sq;
  logic [19:0] v;
  logic [11:0] rem;
  logic [9:0]  root;
  logic [3:0]  k;
  logic [13:0] rem_s;
  logic [13:0] trial;
  logic        take;
  logic [6:0]  dsum;
  logic [5:0]  dmin;
  logic [10:0] lin;

  // Distance sums for the Manhattan and octile estimates
  always_comb begin
    dsum = {1'b0, dx} + {1'b0, dy};
    dmin = (dx < dy) ? dx : dy;
    if (mode == HEUR_OCT) begin
      lin = ({4'd0, dsum} * 11'd10) - ({5'd0, dmin} * 11'd6);
    end else begin
      lin = {4'd0, dsum} * 11'd10;
    end
  end

  // One root bit per step
  always_comb begin
    rem_s = {rem, v[19:18]};
    trial = {2'b00, root, 2'b01};
    take = (rem_s >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= HS_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        HS_IDLE: begin
          if (req.start) begin
            dx <= (req.x > goal_x) ? req.x - goal_x : goal_x - req.x;
            dy <= (req.y > goal_y) ? req.y - goal_y : goal_y - req.y;
            state <= HS_SQ;
          end
        end
        HS_SQ: begin
          sq <= ({7'd0, dx} * {7'd0, dx}) + ({7'd0, dy} * {7'd0, dy});
          if (mode == HEUR_EUCLID) begin
            state <= HS_SCALE;
          end else begin
            h <= lin;
            done <= 1'b1;
            state <= HS_IDLE;
          end
        end
        HS_SCALE: begin
          v <= {7'd0, sq} * 20'd100;
          rem <= '0;
          root <= '0;
          k <= 4'd9;
          state <= HS_ROOT;
        end
        HS_ROOT: begin
          v <= {v[17:0], 2'b00};
          rem <= take ? 12'(rem_s - trial) : 12'(rem_s);
          root <= {root[8:0], take};
          k <= k - 4'd1;
          if (k == 4'd0) begin
            h <= {1'b0, root[8:0], take};
            done <= 1'b1;
            state <= HS_IDLE;
          end
        end
        default: state <= HS_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/gaps_core.sv =====
`default_nettype none
module gaps_core
  import gaps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic req_valid,
  input  wire req_t req,
  output logic      ready,
  output logic      res_valid,
  output res_t      res,
  input  wire logic res_take
);

  typedef enum logic [13:0] {
    ST_WIPE   = 14'b00000000000001,
    ST_IDLE   = 14'b00000000000010,
    ST_CLR    = 14'b00000000000100,
    ST_HSTART = 14'b00000000001000,
    ST_HWAIT  = 14'b00000000010000,
    ST_SCAN   = 14'b00000000100000,
    ST_TAIL   = 14'b00000001000000,
    ST_EVAL   = 14'b00000010000000,
    ST_NB     = 14'b00000100000000,
    ST_NBWAIT = 14'b00001000000000,
    ST_TRACE  = 14'b00010000000000,
    ST_TRWAIT = 14'b00100000000000,
    ST_RDWAIT = 14'b01000000000000,
    ST_RESULT = 14'b10000000000000
  } state_t;

  state_t state;

  // Node and wall memories
  node_t   node_mem [CELLS];
  logic    wall_mem [CELLS];
  logic    node_we;
  logic [AW-1:0] node_waddr;
  node_t   node_wdata;
  logic    node_re;
  logic [AW-1:0] node_raddr;
  node_t   node_rdata;
  logic    wall_we;
  logic [AW-1:0] wall_waddr;
  logic    wall_wdata;
  logic    wall_re;
  logic [AW-1:0] wall_raddr;
  logic    wall_rdata;

  // Control and search registers
  logic [AW-1:0] addr;
  logic        found_flag;
  logic [12:0] path_count;
  logic [AW-1:0] read_cursor;
  logic [12:0] read_remaining;
  logic [5:0]  step_x;
  logic [5:0]  step_y;
  logic        step_valid;
  logic        last_step;
  logic        any;
  logic [16:0] best_f;
  logic [AW-1:0] best_idx;
  node_t       best;
  logic        scan_cmp;
  logic [AW-1:0] scan_idx;
  logic [3:0]  d;
  logic [AW-1:0] nb_idx;
  logic [AW-1:0] trace_idx;
  logic [12:0] trace_cnt;

  // Derived values
  logic [6:0]  w7;
  logic [6:0]  h7;
  logic [AW-1:0] sidx;
  logic [AW-1:0] gidx;
  logic        ends_ok;
  logic [3:0]  ndir;
  logic signed [1:0] ddx;
  logic signed [1:0] ddy;
  logic [7:0]  nx;
  logic [7:0]  ny;
  logic        nb_ok;
  logic [16:0] g_sum;
  logic [15:0] g_new;
  logic [16:0] scan_f;
  logic [12:0] par;
  heur_req_t   hreq;
  logic        hdone;
  logic [10:0] hval;
  logic        accept;

  gaps_heur u_heur (
    .clk    (clk),
    .rst    (rst),
    .req    (hreq),
    .goal_x (cfg.goal_x),
    .goal_y (cfg.goal_y),
    .mode   (cfg.heuristic_mode),
    .done   (hdone),
    .h      (hval)
  );

  always_comb begin
    w7 = (cfg.grid_width > MAX_W) ? MAX_W : cfg.grid_width;
    h7 = (cfg.grid_height > MAX_H) ? MAX_H : cfg.grid_height;
    sidx = {cfg.start_y, cfg.start_x};
    gidx = {cfg.goal_y, cfg.goal_x};
    ends_ok = ({1'b0, cfg.start_x} < w7) && ({1'b0, cfg.start_y} < h7) &&
              ({1'b0, cfg.goal_x} < w7) && ({1'b0, cfg.goal_y} < h7);
    ndir = cfg.eight_way ? 4'd8 : 4'd4;
    ddx = dir_dx(d[2:0]);
    ddy = dir_dy(d[2:0]);
    nx = {2'b00, best_idx[5:0]} + {{6{ddx[1]}}, ddx};
    ny = {2'b00, best_idx[11:6]} + {{6{ddy[1]}}, ddy};
    nb_ok = !nx[7] && !ny[7] && (nx[6:0] < w7) && (ny[6:0] < h7);
    g_sum = {1'b0, best.g} + {12'd0, (d[2] ? COST_DIAG : COST_STRAIGHT)};
    g_new = g_sum[16] ? 16'hFFFF : g_sum[15:0];
    scan_f = {1'b0, node_rdata.g} + {6'd0, node_rdata.h};
    par = parent_of((state == ST_RDWAIT) ? read_cursor : trace_idx, node_rdata.dir);
    accept = req_valid && (state == ST_IDLE);
  end

  // Memory port control
  always_comb begin
    node_we = 1'b0;
    node_waddr = addr;
    node_wdata = '0;
    node_re = 1'b0;
    node_raddr = addr;
    wall_we = 1'b0;
    wall_waddr = addr;
    wall_wdata = 1'b0;
    wall_re = 1'b0;
    wall_raddr = {ny[5:0], nx[5:0]};
    hreq = '0;
    case (state)
      ST_WIPE: wall_we = 1'b1;
      ST_IDLE: begin
        if (accept && req.action == ACT_WALL) begin
          wall_we = 1'b1;
          wall_waddr = {req.cell_y, req.cell_x};
          wall_wdata = req.is_wall;
        end
        if (accept && req.action == ACT_READ) begin
          node_re = 1'b1;
          node_raddr = read_cursor;
        end
      end
      ST_CLR: node_we = 1'b1;
      ST_HSTART: begin
        hreq.start = 1'b1;
        hreq.x = cfg.start_x;
        hreq.y = cfg.start_y;
      end
      ST_HWAIT: begin
        node_we = hdone;
        node_waddr = sidx;
        node_wdata = '{open: 1'b1, closed: 1'b0, g: 16'd0, h: hval, dir: 3'd0};
      end
      ST_SCAN: node_re = 1'b1;
      ST_EVAL: begin
        node_we = any && (best_idx != gidx);
        node_waddr = best_idx;
        node_wdata = best;
        node_wdata.open = 1'b0;
        node_wdata.closed = 1'b1;
      end
      ST_NB: begin
        if (d != ndir && nb_ok) begin
          node_re = 1'b1;
          node_raddr = {ny[5:0], nx[5:0]};
          wall_re = 1'b1;
          hreq.start = 1'b1;
          hreq.x = nx[5:0];
          hreq.y = ny[5:0];
        end
      end
      ST_NBWAIT: begin
        node_waddr = nb_idx;
        if (hdone && !wall_rdata && !node_rdata.closed) begin
          if (!node_rdata.open) begin
            node_we = 1'b1;
            node_wdata = '{open: 1'b1, closed: 1'b0, g: g_new, h: hval, dir: d[2:0]};
          end else if (g_new < node_rdata.g) begin
            node_we = 1'b1;
            node_wdata = node_rdata;
            node_wdata.g = g_new;
            node_wdata.dir = d[2:0];
          end
        end
      end
      ST_TRACE: begin
        node_re = 1'b1;
        node_raddr = trace_idx;
      end
      default: ;
    endcase
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (node_re) begin
      node_rdata <= node_mem[node_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (wall_we) begin
      wall_mem[wall_waddr] <= wall_wdata;
    end
    if (wall_re) begin
      wall_rdata <= wall_mem[wall_raddr];
    end
  end

  // Scan compare: keep the least G+H, later cells win ties
  always_ff @(posedge clk) begin
    scan_cmp <= (state == ST_SCAN);
    scan_idx <= addr;
    if ((state == ST_HWAIT && hdone) || (state == ST_NB && d == ndir)) begin
      any <= 1'b0;
    end else if (scan_cmp && node_rdata.open && (!any || scan_f <= best_f)) begin
      any <= 1'b1;
      best_f <= scan_f;
      best_idx <= scan_idx;
      best <= node_rdata;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WIPE;
      addr <= '0;
      found_flag <= 1'b0;
      path_count <= '0;
      read_cursor <= '0;
      read_remaining <= '0;
      step_valid <= 1'b0;
      last_step <= 1'b0;
    end else begin
      case (state)
        ST_WIPE: begin
          addr <= addr + 1'b1;
          if (addr == AW'(CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            step_x <= '0;
            step_y <= '0;
            step_valid <= 1'b0;
            last_step <= 1'b0;
            state <= ST_RESULT;
            case (req.action)
              ACT_SEARCH: begin
                found_flag <= 1'b0;
                path_count <= '0;
                read_cursor <= '0;
                read_remaining <= '0;
                addr <= '0;
                state <= ST_CLR;
              end
              ACT_READ: begin
                if (read_remaining != 13'd0) begin
                  step_x <= read_cursor[5:0];
                  step_y <= read_cursor[11:6];
                  step_valid <= 1'b1;
                  last_step <= (read_remaining == 13'd1);
                  read_remaining <= read_remaining - 13'd1;
                  if (read_remaining != 13'd1) begin
                    state <= ST_RDWAIT;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_RDWAIT: begin
          if (par[12]) begin
            read_cursor <= par[11:0];
          end
          state <= ST_RESULT;
        end
        ST_CLR: begin
          addr <= addr + 1'b1;
          if (addr == AW'(CELLS - 1)) begin
            state <= ends_ok ? ST_HSTART : ST_RESULT;
          end
        end
        ST_HSTART: state <= ST_HWAIT;
        ST_HWAIT: begin
          if (hdone) begin
            addr <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          addr <= addr + 1'b1;
          if (addr == AW'(CELLS - 1)) begin
            state <= ST_TAIL;
          end
        end
        ST_TAIL: state <= ST_EVAL;
        ST_EVAL: begin
          d <= '0;
          if (!any) begin
            state <= ST_RESULT;
          end else if (best_idx == gidx) begin
            trace_idx <= gidx;
            trace_cnt <= 13'd1;
            state <= ST_TRACE;
          end else begin
            state <= ST_NB;
          end
        end
        ST_NB: begin
          if (d == ndir) begin
            addr <= '0;
            state <= ST_SCAN;
          end else if (!nb_ok) begin
            d <= d + 4'd1;
          end else begin
            nb_idx <= {ny[5:0], nx[5:0]};
            state <= ST_NBWAIT;
          end
        end
        ST_NBWAIT: begin
          if (hdone) begin
            d <= d + 4'd1;
            state <= ST_NB;
          end
        end
        ST_TRACE: begin
          if (trace_idx == sidx || trace_cnt >= CELL_COUNT) begin
            found_flag <= 1'b1;
            path_count <= trace_cnt;
            read_cursor <= gidx;
            read_remaining <= trace_cnt;
            state <= ST_RESULT;
          end else begin
            state <= ST_TRWAIT;
          end
        end
        ST_TRWAIT: begin
          if (par[12]) begin
            trace_idx <= par[11:0];
            trace_cnt <= trace_cnt + 13'd1;
            state <= ST_TRACE;
          end else begin
            found_flag <= 1'b1;
            path_count <= trace_cnt;
            read_cursor <= gidx;
            read_remaining <= trace_cnt;
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (res_take) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign ready = (state == ST_IDLE);
  assign res_valid = (state == ST_RESULT);
  assign res = '{found: found_flag, path_length: path_count, step_x: step_x,
                 step_y: step_y, step_valid: step_valid, last_step: last_step};

endmodule
`default_nettype wire
